FILE: hdl/fvsm_pkg.sv
// ----------------------------------------------------------------------------
// Four-voice sine mixer package
// Shared types, register indexes and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package fvsm_pkg;

  localparam int unsigned TABLE_BITS = 10;
  localparam int unsigned QUARTER    = 1 << (TABLE_BITS - 2);
  localparam int unsigned QIDX_W     = TABLE_BITS - 1;
  localparam int unsigned CFG_VOICES = 4;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 32;

  typedef logic signed [15:0] sample_t;
  typedef logic [15:0]        gain_t;
  typedef logic [30:0]        step_t;
  typedef logic [14:0]        mag_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t REG_STEP_ZERO  = 4'd0;
  localparam cfg_idx_t REG_STEP_ONE   = 4'd1;
  localparam cfg_idx_t REG_STEP_TWO   = 4'd2;
  localparam cfg_idx_t REG_STEP_THREE = 4'd3;
  localparam cfg_idx_t REG_GAIN_ZERO  = 4'd4;
  localparam cfg_idx_t REG_GAIN_ONE   = 4'd5;
  localparam cfg_idx_t REG_GAIN_TWO   = 4'd6;
  localparam cfg_idx_t REG_GAIN_THREE = 4'd7;

  localparam step_t   STEP_RESET  = 31'd24347;
  localparam gain_t   GAIN0_RESET = 16'd16384;
  localparam sample_t SAMPLE_MAX  = 16'sh7FFF;
  localparam sample_t SAMPLE_MIN  = -16'sh8000;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef struct packed {
    logic advance;
    logic restart;
  } voice_ctrl_t;

  typedef mag_t sine_rom_t [QUARTER+1];

  // Magnitude of sin(pi/2 * r / QUARTER) in Q15 from a Taylor series in Q30.
  function automatic mag_t sine_mag(int unsigned r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] mag;
    x    = (64'(r) * HALF_PI_Q30) >> (TABLE_BITS - 2);
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    mag  = (sum + 64'd16384) >> 15;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    return mag[14:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int unsigned i = 0; i <= QUARTER; i++) begin
      rom[i] = sine_mag(i);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

FILE: hdl/fvsm_if.sv
// ----------------------------------------------------------------------------
// Four-voice sine mixer channel interfaces
// Frame input, frame output and configuration write channels.
// ----------------------------------------------------------------------------
interface fvsm_frame_in_if;
  logic              valid;
  logic              ready;
  fvsm_pkg::sample_t left_in;
  fvsm_pkg::sample_t right_in;
  logic              restart_phase;

  modport source (output valid, left_in, right_in, restart_phase, input ready);
  modport sink   (input valid, left_in, right_in, restart_phase, output ready);
endinterface

interface fvsm_frame_out_if;
  logic              valid;
  logic              ready;
  fvsm_pkg::sample_t left_out;
  fvsm_pkg::sample_t right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

interface fvsm_cfg_if;
  logic                valid;
  logic                ready;
  fvsm_pkg::cfg_idx_t  index;
  fvsm_pkg::cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/fvsm_voice.sv
// ----------------------------------------------------------------------------
// Four-voice sine mixer oscillator
// Phase accumulator of one voice and its registered sine table lookup.
// ----------------------------------------------------------------------------
module fvsm_voice #(
  parameter int unsigned PHASE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fvsm_pkg::voice_ctrl_t ctrl_i,
  input  fvsm_pkg::step_t       step_i,
  output fvsm_pkg::sample_t     sine_o
);
  import fvsm_pkg::*;

  logic [PHASE_BITS-1:0] phase_q, phase_d;
  logic [PHASE_BITS-1:0] phase_eff;
  logic [TABLE_BITS-1:0] tab_idx;
  logic [1:0]            quad;
  logic [QIDX_W-1:0]     rom_idx;
  mag_t                  mag;
  sample_t               sine_d, sine_q;

  assign phase_eff = ctrl_i.restart ? '0 : phase_q;
  assign phase_d   = phase_eff + PHASE_BITS'(step_i);
  assign tab_idx   = phase_eff[PHASE_BITS-1 -: TABLE_BITS];
  assign quad      = tab_idx[TABLE_BITS-1 -: 2];

  always_comb begin
    if (quad[0]) begin
      rom_idx = QIDX_W'(QUARTER) - {1'b0, tab_idx[TABLE_BITS-3:0]};
    end else begin
      rom_idx = {1'b0, tab_idx[TABLE_BITS-3:0]};
    end
    mag = SINE_ROM[rom_idx];
    if (quad[1]) begin
      sine_d = -$signed({1'b0, mag});
    end else begin
      sine_d = $signed({1'b0, mag});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (ctrl_i.advance) begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance) begin
      sine_q <= sine_d;
    end
  end

  assign sine_o = sine_q;

endmodule

FILE: hdl/fvsm_mix.sv
// ----------------------------------------------------------------------------
// Four-voice sine mixer summing stage
// Scales each voice by its gain, sums, truncates and saturates both channels.
// ----------------------------------------------------------------------------
module fvsm_mix #(
  parameter int unsigned VOICE_COUNT = 4
) (
  input  fvsm_pkg::sample_t sine_i [VOICE_COUNT],
  input  fvsm_pkg::gain_t   gain_i [VOICE_COUNT],
  input  fvsm_pkg::sample_t left_i,
  input  fvsm_pkg::sample_t right_i,
  output fvsm_pkg::sample_t left_o,
  output fvsm_pkg::sample_t right_o
);
  import fvsm_pkg::*;

  localparam int unsigned PROD_W = 33;
  localparam int unsigned ACC_W  = PROD_W + $clog2(VOICE_COUNT);
  localparam int unsigned TONE_W = ACC_W - 15;
  localparam int unsigned MIX_W  = TONE_W + 1;

  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_adj;
  logic signed [TONE_W-1:0] tone;

  function automatic sample_t sat16(logic signed [MIX_W-1:0] v);
    sample_t res;
    if (v > MIX_W'(SAMPLE_MAX)) begin
      res = SAMPLE_MAX;
    end else if (v < MIX_W'(SAMPLE_MIN)) begin
      res = SAMPLE_MIN;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

  always_comb begin
    logic signed [PROD_W-1:0] prod;
    acc = '0;
    for (int v = 0; v < VOICE_COUNT; v++) begin
      prod = sine_i[v] * $signed({1'b0, gain_i[v]});
      acc  = acc + ACC_W'(prod);
    end
  end

  // Rounding toward zero: bias negative sums before the arithmetic shift.
  assign acc_adj = acc + (acc[ACC_W-1] ? ACC_W'(32767) : ACC_W'(0));
  assign tone    = acc_adj[ACC_W-1:15];

  assign left_o  = sat16(MIX_W'(left_i) + MIX_W'(tone));
  assign right_o = sat16(MIX_W'(right_i) + MIX_W'(tone));

endmodule

FILE: hdl/four_voice_sine_mixer.sv
// ----------------------------------------------------------------------------
// Four-voice sine mixer
// Bank of sine oscillators added into a stereo 16-bit sample stream.
// ----------------------------------------------------------------------------
// Usage: every request on in_req_i carries one stereo frame and a restart
// flag; a set flag clears all voice phases before that frame is mixed.
// Every frame yields exactly one request on out_req_o with both channels
// plus the tone sum, saturated to 16 bits.
// The block is a two-stage pipeline: the first stage steps the phase
// accumulators and reads the quarter-wave sine table, the second scales,
// sums and saturates. An accepted frame passes through the first-stage
// registers into the output register, and one frame is accepted in every
// cycle while the receiver does not stall.
// When the receiver stalls, the result is held in the output register;
// the first stage still takes a frame only while it is empty, and
// in_req_i drops ready once that stage holds one.
// Registers on cfg_i are step_zero..step_three (index 0 to 3) and
// gain_zero..gain_three (index 4 to 7); writes are always accepted and
// others are ignored. Reset clears all phases and the pipeline, and
// restores steps to 24347 and gains to 16384 for voice zero, 0 elsewhere.
// ----------------------------------------------------------------------------
module four_voice_sine_mixer #(
  parameter int unsigned VOICE_COUNT = 4,
  parameter int unsigned PHASE_BITS  = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  fvsm_frame_in_if.sink  in_req_i,
  fvsm_frame_out_if.source out_req_o,
  fvsm_cfg_if.sink       cfg_i
);
  import fvsm_pkg::*;

  logic        in_acc;
  logic        cfg_acc;
  logic        s1_adv;
  logic        s1_valid_q, s1_valid_d;
  logic        out_valid_q, out_valid_d;
  voice_ctrl_t voice_ctrl;
  sample_t     s1_left_q, s1_right_q;
  sample_t     mix_left, mix_right;
  sample_t     out_left_q, out_right_q;
  step_t       step [VOICE_COUNT];
  gain_t       gain [VOICE_COUNT];
  sample_t     sine [VOICE_COUNT];

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;

  assign s1_adv         = !out_valid_q || out_req_o.ready;
  assign in_req_i.ready = !s1_valid_q || s1_adv;
  assign in_acc         = in_req_i.valid && in_req_i.ready;

  assign voice_ctrl.advance = in_acc;
  assign voice_ctrl.restart = in_req_i.restart_phase;

  for (genvar v = 0; v < VOICE_COUNT; v++) begin : g_voice
    if (v < CFG_VOICES) begin : g_cfg
      step_t step_q;
      gain_t gain_q;

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          step_q <= STEP_RESET;
          gain_q <= (v == 0) ? GAIN0_RESET : '0;
        end else if (cfg_acc) begin
          if (cfg_i.index == REG_STEP_ZERO + cfg_idx_t'(v)) begin
            step_q <= cfg_i.data[30:0];
          end
          if (cfg_i.index == REG_GAIN_ZERO + cfg_idx_t'(v)) begin
            gain_q <= cfg_i.data[15:0];
          end
        end
      end

      assign step[v] = step_q;
      assign gain[v] = gain_q;
    end else begin : g_fixed
      assign step[v] = STEP_RESET;
      assign gain[v] = '0;
    end

    fvsm_voice #(
      .PHASE_BITS(PHASE_BITS)
    ) u_voice (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctrl_i(voice_ctrl),
      .step_i(step[v]),
      .sine_o(sine[v])
    );
  end

  fvsm_mix #(
    .VOICE_COUNT(VOICE_COUNT)
  ) u_mix (
    .sine_i (sine),
    .gain_i (gain),
    .left_i (s1_left_q),
    .right_i(s1_right_q),
    .left_o (mix_left),
    .right_o(mix_right)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_left_q  <= in_req_i.left_in;
      s1_right_q <= in_req_i.right_in;
    end
    if (s1_adv && s1_valid_q) begin
      out_left_q  <= mix_left;
      out_right_q <= mix_right;
    end
  end

  assign out_req_o.valid     = out_valid_q;
  assign out_req_o.left_out  = out_left_q;
  assign out_req_o.right_out = out_right_q;

  a_full_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_req_o.ready |-> !in_req_i.ready)
    else $error("input taken while both stages are full and stalled");

  a_accept_fills_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted frame did not reach the first stage");

  a_output_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_valid_q))
    else $error("result raised without a frame in the first stage");

  a_stage_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_adv && !in_acc |=> !s1_valid_q && out_valid_q)
    else $error("first stage did not hand its frame to the output");

endmodule
